/* rtl/core/lrukv_pkg.sv */
package lrukv_pkg;

    // number of cache slots
    localparam int ENTRIES = 16;
    // slot index and recency rank width
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // occupancy counter width, holds 0..ENTRIES
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    // capacity register width and reset value
    localparam int CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    // item field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    // tdata widths, padded to whole bytes
    localparam int S_DATA_W = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int M_RAW_W  = 1 + VAL_W + 1 + KEY_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    // item kinds carried on s_tuser
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

endpackage

/* rtl/core/lru_key_value_cache_unit.sv */
// Items are handled one at a time: the 16-entry key memory is scanned one entry
// a cycle through its single read port, then the item commits once the result
// register is free; a new item is accepted only after that commit.
// Reset (aresetn low, synchronous): all entries invalid, occupancy zero,
// capacity_limit back to 16, no result pending. Key/value memories not cleared.
module lru_key_value_cache_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: capacity_limit
    input  logic                               cfg_we,
    input  logic [lrukv_pkg::CAP_W-1:0]        cfg_wdata,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lrukv_pkg::S_DATA_W-1:0]     s_tdata,  // lookup_key, write_value
    input  logic                               s_tuser,  // mode
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrukv_pkg::M_DATA_W-1:0]     m_tdata   // found, read_value, evicted,
                                                         // evicted_key, zero pad
);

    localparam int IDX_W = lrukv_pkg::IDX_W;
    localparam int OCC_W = lrukv_pkg::OCC_W;
    localparam int KEY_W = lrukv_pkg::KEY_W;
    localparam int VAL_W = lrukv_pkg::VAL_W;
    localparam int ENT   = lrukv_pkg::ENTRIES;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_RESP} state_t;

    state_t                     state_reg;
    logic [lrukv_pkg::CAP_W-1:0] cap_reg;

    // per-entry status in flops
    logic [ENT-1:0]             valid_reg, valid_next;
    logic [IDX_W-1:0]           rank_reg [ENT];
    logic [IDX_W-1:0]           rank_next [ENT];
    logic [OCC_W-1:0]           occ_reg, occ_next;

    // item being worked on
    logic                       mode_reg;
    logic [KEY_W-1:0]           key_reg;
    logic [VAL_W-1:0]           val_reg;

    // scan control
    logic [IDX_W-1:0]           addr_reg;
    logic                       cmp_pend_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic                       hit_reg;
    logic [IDX_W-1:0]           slot_reg;
    logic [VAL_W-1:0]           hit_value_reg;
    logic [KEY_W-1:0]           victim_key_reg;

    // result register
    logic                       m_tvalid_reg;
    logic                       res_found_reg;
    logic [VAL_W-1:0]           res_rd_reg;
    logic                       res_ev_reg;
    logic [KEY_W-1:0]           res_evkey_reg;

    // memory ports
    logic                       key_we, val_we;
    logic [IDX_W-1:0]           wr_slot;
    logic                       ram_re;
    logic [KEY_W-1:0]           key_rdata;
    logic [VAL_W-1:0]           val_rdata;

    // commit path
    logic                       commit;
    logic [31:0]                cap_ext, eff_cap;
    logic                       need_evict;
    logic                       victim_have, free_have;
    logic [IDX_W-1:0]           victim_idx, free_idx;
    logic                       res_found, res_ev;
    logic [VAL_W-1:0]           res_rd;
    logic [KEY_W-1:0]           res_evkey;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(lrukv_pkg::M_DATA_W - lrukv_pkg::M_RAW_W)'(0),
                       res_evkey_reg, res_ev_reg, res_rd_reg, res_found_reg};

    assign ram_re = (state_reg == ST_SCAN);
    assign commit = (state_reg == ST_RESP) && (!m_tvalid_reg || m_tready);

    lrukv_ram #(.WIDTH(KEY_W), .DEPTH(ENT)) u_key_ram (
        .clk   (aclk),
        .we    (key_we),
        .waddr (wr_slot),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (key_rdata)
    );

    lrukv_ram #(.WIDTH(VAL_W), .DEPTH(ENT)) u_val_ram (
        .clk   (aclk),
        .we    (val_we),
        .waddr (wr_slot),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (val_rdata)
    );

    // effective capacity, clamped to 1..ENTRIES
    always_comb begin
        cap_ext = 32'(cap_reg);
        if (cap_ext == 32'd0) begin
            eff_cap = 32'd1;
        end else if (cap_ext > 32'(ENT)) begin
            eff_cap = 32'(ENT);
        end else begin
            eff_cap = cap_ext;
        end
        need_evict = (occ_reg != '0) && (32'(occ_reg) >= eff_cap);
    end

    // least recent valid entry and lowest free slot, lowest index wins
    always_comb begin
        victim_have = 1'b0;
        victim_idx  = '0;
        free_have   = 1'b0;
        free_idx    = '0;
        for (int i = ENT - 1; i >= 0; i--) begin
            if (valid_reg[i] && rank_reg[i] == IDX_W'(occ_reg - OCC_W'(1))) begin
                victim_have = 1'b1;
                victim_idx  = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_have = 1'b1;
                free_idx  = IDX_W'(i);
            end
        end
    end

    // read-modify-write of status and memories at commit
    always_comb begin
        logic [ENT-1:0]   valid_tmp;
        logic [IDX_W-1:0] r;
        logic             ins_have;
        logic             ev_do;
        logic [IDX_W-1:0] ins_slot;

        valid_tmp = valid_reg;
        r         = rank_reg[slot_reg];
        ins_have  = 1'b0;
        ev_do     = 1'b0;
        ins_slot  = free_idx;

        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        key_we     = 1'b0;
        val_we     = 1'b0;
        wr_slot    = slot_reg;

        res_found = hit_reg;
        res_ev    = 1'b0;
        res_evkey = '0;
        if (mode_reg == lrukv_pkg::MODE_SET) begin
            res_rd = val_reg;
        end else if (hit_reg) begin
            res_rd = hit_value_reg;
        end else begin
            res_rd = '1;
        end

        if (commit) begin
            if (hit_reg) begin
                // promote: more recent entries age by one
                for (int i = 0; i < ENT; i++) begin
                    if (valid_reg[i] && rank_reg[i] < r) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_next[slot_reg] = '0;
                val_we = (mode_reg == lrukv_pkg::MODE_SET);
            end else if (mode_reg == lrukv_pkg::MODE_SET) begin
                ev_do = need_evict && victim_have;
                if (ev_do) begin
                    valid_tmp[victim_idx] = 1'b0;
                    ins_slot  = victim_idx;
                    ins_have  = 1'b1;
                    res_ev    = 1'b1;
                    res_evkey = victim_key_reg;
                end else if (free_have) begin
                    ins_slot = free_idx;
                    ins_have = 1'b1;
                end
                if (ins_have) begin
                    for (int i = 0; i < ENT; i++) begin
                        if (valid_tmp[i]) begin
                            rank_next[i] = rank_reg[i] + IDX_W'(1);
                        end
                    end
                    valid_tmp[ins_slot] = 1'b1;
                    rank_next[ins_slot] = '0;
                    occ_next = ev_do ? occ_reg : occ_reg + OCC_W'(1);
                    key_we   = 1'b1;
                    val_we   = 1'b1;
                    wr_slot  = ins_slot;
                end
                valid_next = valid_tmp;
            end
        end
    end

    // sequencer, status and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= lrukv_pkg::CAP_RESET;
            valid_reg    <= '0;
            for (int i = 0; i < ENT; i++) begin
                rank_reg[i] <= '0;
            end
            occ_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end

            // compare the entry read in the previous cycle
            if (cmp_pend_reg) begin
                if (valid_reg[cmp_idx_reg] && key_rdata == key_reg && !hit_reg) begin
                    hit_reg       <= 1'b1;
                    slot_reg      <= cmp_idx_reg;
                    hit_value_reg <= val_rdata;
                end
                if (cmp_idx_reg == victim_idx) begin
                    victim_key_reg <= key_rdata;
                end
            end

            // result taken and no new one replacing it
            if (m_tready && !commit) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg     <= s_tuser;
                        key_reg      <= s_tdata[KEY_W-1:0];
                        val_reg      <= s_tdata[KEY_W+VAL_W-1:KEY_W];
                        addr_reg     <= '0;
                        hit_reg      <= 1'b0;
                        cmp_pend_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    cmp_pend_reg <= 1'b1;
                    cmp_idx_reg  <= addr_reg;
                    addr_reg     <= addr_reg + IDX_W'(1);
                    if (addr_reg == IDX_W'(ENT - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    cmp_pend_reg <= 1'b0;
                    state_reg    <= ST_RESP;
                end
                ST_RESP: begin
                    if (commit) begin
                        valid_reg     <= valid_next;
                        rank_reg      <= rank_next;
                        occ_reg       <= occ_next;
                        m_tvalid_reg  <= 1'b1;
                        res_found_reg <= res_found;
                        res_rd_reg    <= res_rd;
                        res_ev_reg    <= res_ev;
                        res_evkey_reg <= res_evkey;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/lrukv_ram.sv */
module lrukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/lrukv_checker.sv */
module lrukv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lrukv_pkg::M_DATA_W-1:0] m_tdata
);

    // a held result keeps its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // no result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item at a time: input closes after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // an eviction only happens on a miss
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> !m_tdata[0])
        else $error("eviction reported on a hit");

    // evicted key is zero when nothing was evicted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[33] |-> m_tdata[65:34] == 32'd0)
        else $error("stray evicted key");

endmodule

bind lru_key_value_cache_unit lrukv_checker u_lrukv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/lru_key_value_cache_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both item channels, keeps its own copy
// of the cache state, and compares every result item field by field.
module lru_key_value_cache_checker
    import lrukv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  outstanding,
    output int                  mismatch_count
);

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_reply_t;

    // shadow copy of the cache
    logic [KEY_W-1:0] slot_key  [ENTRIES];
    logic [VAL_W-1:0] slot_val  [ENTRIES];
    logic             slot_live [ENTRIES];
    int unsigned      slot_age  [ENTRIES];
    int unsigned      live_count;
    logic [CAP_W-1:0] capacity;

    cache_reply_t predicted_replies[$];
    int           mismatches = 0;

    assign mismatch_count = mismatches;

    // apply one get or set to the shadow cache and work out its reply
    function automatic cache_reply_t access_cache(input logic mode,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] val);
        cache_reply_t reply;
        int           hit_slot;
        int           target;
        int unsigned  age;
        int unsigned  cap;
        reply    = '0;
        hit_slot = -1;
        target   = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_slot < 0 && slot_live[i] && slot_key[i] == key)
                hit_slot = i;
        end

        if (hit_slot >= 0) begin
            // hit: entries newer than this one age by one, this one becomes newest
            age = slot_age[hit_slot];
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_live[i] && slot_age[i] < age)
                    slot_age[i]++;
            end
            slot_age[hit_slot] = 0;
            if (mode == MODE_SET)
                slot_val[hit_slot] = val;
            reply.found      = 1'b1;
            reply.read_value = slot_val[hit_slot];
        end else if (mode == MODE_GET) begin
            reply.read_value = '1;
        end else begin
            reply.read_value = val;
            // capacity zero acts as one, anything above the slot count as full size
            cap = 32'(capacity);
            if (cap < 1)
                cap = 1;
            if (cap > ENTRIES)
                cap = ENTRIES;
            if (live_count >= cap && live_count > 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (target < 0 && slot_live[i] && slot_age[i] == live_count - 1)
                        target = i;
                end
                if (target >= 0) begin
                    reply.evicted     = 1'b1;
                    reply.evicted_key = slot_key[target];
                    slot_live[target] = 1'b0;
                    live_count--;
                end
            end
            // no eviction: lowest free slot
            if (target < 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (target < 0 && !slot_live[i])
                        target = i;
                end
            end
            if (target >= 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_live[i])
                        slot_age[i]++;
                end
                slot_key[target]  = key;
                slot_val[target]  = val;
                slot_live[target] = 1'b1;
                slot_age[target]  = 0;
                live_count++;
            end
        end
        return reply;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
    endtask

    // channel monitor
    always @(posedge aclk) begin
        cache_reply_t want;
        cache_reply_t got;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_live[i] = 1'b0;
                slot_age[i]  = 0;
            end
            live_count = 0;
            capacity   = CAP_RESET;
            predicted_replies.delete();
            outstanding <= 0;
        end else begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_tvalid && s_tready)
                predicted_replies.push_back(access_cache(s_tuser, s_tdata[KEY_W-1:0],
                                                         s_tdata[KEY_W +: VAL_W]));
            if (m_tvalid && m_tready) begin
                got.found       = m_tdata[0];
                got.read_value  = m_tdata[1 +: VAL_W];
                got.evicted     = m_tdata[1 + VAL_W];
                got.evicted_key = m_tdata[2 + VAL_W +: KEY_W];
                if (predicted_replies.size() == 0) begin
                    note_mismatch("unrequested item (read_value)", '0, got.read_value);
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.found !== want.found)
                        note_mismatch("found", 32'(want.found), 32'(got.found));
                    if (got.read_value !== want.read_value)
                        note_mismatch("read_value", want.read_value, got.read_value);
                    if (got.evicted !== want.evicted)
                        note_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
                    if (got.evicted_key !== want.evicted_key)
                        note_mismatch("evicted_key", want.evicted_key, got.evicted_key);
                end
            end
            outstanding <= predicted_replies.size();
        end
    end

endmodule

/* test/lru_key_value_cache_unit_tb.sv */
`timescale 1ns / 1ps

module lru_key_value_cache_unit_tb;
    import lrukv_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 175;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = MODE_GET;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int outstanding;
    int mismatch_count;
    int cycle_count = 0;
    int send_idle   = 0;
    int recv_idle   = 0;

    logic [KEY_W-1:0] key_pool [32];
    int               pool_size;
    logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd1, 5'd31, 5'd16, 5'd3, 5'd0,
                                              5'd8, 5'd17, 5'd5, 5'd16};
    logic [KEY_W-1:0] edge_keys [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF};

    lru_key_value_cache_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lru_key_value_cache_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    always #4 aclk = ~aclk;

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // present one item, holding tvalid high until it is taken
    task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {val, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every predicted item has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int cap_eff;
        int pause_at;
        logic [KEY_W-1:0] key;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty miss, extreme keys and values, set hit, get hit/miss
        send_item(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_SET, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(MODE_SET, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(MODE_GET, 32'h1234_5678, 32'h5555_AAAA);
        send_item(MODE_GET, 32'hFFFF_FFFF, $urandom());
        // fill all sixteen slots, then one more set evicts the oldest
        for (int i = 1; i <= 12; i++)
            send_item(MODE_SET, i, $urandom());
        send_item(MODE_SET, 32'd100, $urandom());
        // capacity lowered below occupancy: a set miss swaps one entry
        write_capacity(5'd2);
        send_item(MODE_SET, 32'd200, $urandom());
        send_item(MODE_GET, 32'd1, $urandom());
        // capacity zero behaves as one
        write_capacity(5'd0);
        send_item(MODE_SET, 32'd300, $urandom());

        // random phases over several capacity settings and idling patterns
        for (int p = 0; p < PHASES; p++) begin
            send_idle = (p < 3) ? 33 : (p < 6) ? 59 : 0;
            recv_idle = (p < 3) ? 59 : (p < 6) ? 33 : 0;
            write_capacity(phase_caps[p]);

            // working set a little larger than the capacity, so hits and evictions mix
            cap_eff   = (phase_caps[p] == 0) ? 1 :
                        (phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
            pool_size = cap_eff + $urandom_range(1, 6);
            for (int i = 0; i < 32; i++)
                key_pool[i] = ($urandom_range(7) == 0) ? edge_keys[$urandom_range(3)]
                                                       : $urandom();
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at)
                    drain_results();
                key = ($urandom_range(9) == 0) ? $urandom()
                                               : key_pool[$urandom_range(pool_size - 1)];
                send_item(($urandom_range(99) < 45) ? MODE_SET : MODE_GET, key, $urandom());
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
